// ----- rtl/flt_pkg.sv -----
// ---------------------------------------------------------------------------
// flt_pkg
// Shared types, constants and codes of the flow request latency tracker.
// ---------------------------------------------------------------------------
package flt_pkg;

   localparam int TABLE_ENTRIES_DEF = 8192;
   localparam int TABLE_WAYS_DEF    = 4;
   localparam int BIN_COUNT_DEF     = 24;

   localparam logic [15:0] PORT_RESET = 16'd53;
   localparam logic [9:0]  NS_PER_US  = 10'd1000;
   // ceil(2^30 / 125): floor(u / 125) = (u * DIV_RECIP) >> 30 for u < 2^23
   localparam logic [23:0] DIV_RECIP  = 24'd8589935;

   localparam int KEY_W   = 96;
   localparam int TIME_W  = 64;
   localparam int ENTRY_W = KEY_W + TIME_W;

   localparam logic [1:0] ACT_REQUEST = 2'd0;
   localparam logic [1:0] ACT_REPLY   = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   localparam logic [2:0] ST_IGNORED   = 3'd0;
   localparam logic [2:0] ST_STORED    = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NOMATCH   = 3'd3;
   localparam logic [2:0] ST_BACKWARDS = 3'd4;
   localparam logic [2:0] ST_COUNTED   = 3'd5;
   localparam logic [2:0] ST_READ      = 3'd6;

   localparam logic [3:0] HASH_LAST = 4'd3;
   localparam logic [3:0] DIV_LAST  = 4'd7;

   localparam logic [0:0] REG_WATCHED_PORT = 1'b0;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] local_addr;
      logic [31:0] remote_addr;
      logic [15:0] local_port;
      logic [15:0] remote_port;
      logic [63:0] time_ns;
      logic        reply_ok;
      logic [4:0]  bin_select;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  bucket;
      logic [54:0] latency_us;
      logic [63:0] bin_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_LOOKUP,
      S_MATCH,
      S_DIV,
      S_BINUP,
      S_BINRD
   } state_type;

   typedef struct packed {
      logic       load;
      logic       hash;
      logic       rd;
      logic       wr_req;
      logic       wr_rem;
      logic       sub;
      logic       div;
      logic       bin_inc;
      logic       clr;
      logic       respond;
      logic [2:0] status;
      logic [3:0] step;
   } cmd_type;

   typedef struct packed {
      logic watched;
      logic clr_last;
      logic is_req;
      logic hit;
      logic slot_ok;
      logic backwards;
   } sts_type;

endpackage

// ----- rtl/flt_ram.sv -----
// ---------------------------------------------------------------------------
// flt_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module flt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/flt_ctrl.sv -----
// ---------------------------------------------------------------------------
// flt_ctrl
// Sequencer: clearing pass, set hash, lookup, update, latency division, bin update, bin read.
// ---------------------------------------------------------------------------
module flt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  flt_pkg::req_type  req_payload,
   input  flt_pkg::sts_type  sts,
   output logic              busy,
   output flt_pkg::cmd_type  cmd
);

   flt_pkg::state_type state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flt_pkg::S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.step = cnt_ff;
      busy     = 1'b1;
      case (state_ff)
         flt_pkg::S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = flt_pkg::S_IDLE;
            end
         end
         flt_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               if (req_payload.action == flt_pkg::ACT_READ) begin
                  state_in = flt_pkg::S_BINRD;
               end else if (sts.watched && (req_payload.action == flt_pkg::ACT_REQUEST ||
                            (req_payload.action == flt_pkg::ACT_REPLY &&
                             req_payload.reply_ok))) begin
                  state_in = flt_pkg::S_HASH;
               end else begin
                  cmd.respond = 1'b1;
                  cmd.status  = flt_pkg::ST_IGNORED;
               end
            end
         end
         flt_pkg::S_HASH: begin
            cmd.hash = 1'b1;
            cnt_in   = cnt_ff + 4'd1;
            if (cnt_ff == flt_pkg::HASH_LAST) begin
               state_in = flt_pkg::S_LOOKUP;
            end
         end
         flt_pkg::S_LOOKUP: begin
            cmd.rd   = 1'b1;
            state_in = flt_pkg::S_MATCH;
         end
         flt_pkg::S_MATCH: begin
            state_in = flt_pkg::S_IDLE;
            if (sts.is_req) begin
               cmd.respond = 1'b1;
               if (sts.slot_ok) begin
                  cmd.wr_req = 1'b1;
                  cmd.status = flt_pkg::ST_STORED;
               end else begin
                  cmd.status = flt_pkg::ST_FULL;
               end
            end else if (!sts.hit) begin
               cmd.respond = 1'b1;
               cmd.status  = flt_pkg::ST_NOMATCH;
            end else begin
               cmd.wr_rem = 1'b1;
               if (sts.backwards) begin
                  cmd.respond = 1'b1;
                  cmd.status  = flt_pkg::ST_BACKWARDS;
               end else begin
                  cmd.sub  = 1'b1;
                  cnt_in   = '0;
                  state_in = flt_pkg::S_DIV;
               end
            end
         end
         flt_pkg::S_DIV: begin
            cmd.div = 1'b1;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == flt_pkg::DIV_LAST) begin
               state_in = flt_pkg::S_BINUP;
            end
         end
         flt_pkg::S_BINUP: begin
            cmd.bin_inc = 1'b1;
            cmd.respond = 1'b1;
            cmd.status  = flt_pkg::ST_COUNTED;
            state_in    = flt_pkg::S_IDLE;
         end
         flt_pkg::S_BINRD: begin
            cmd.respond = 1'b1;
            cmd.status  = flt_pkg::ST_READ;
            state_in    = flt_pkg::S_IDLE;
         end
         default: begin
            state_in = flt_pkg::S_CLEAR;
         end
      endcase
   end

endmodule

// ----- rtl/flt_dp.sv -----
// ---------------------------------------------------------------------------
// flt_dp
// Datapath: flow table, set hash, divider by 1000, histogram bins, CSR.
// ---------------------------------------------------------------------------
module flt_dp #(
   parameter int TABLE_ENTRIES = flt_pkg::TABLE_ENTRIES_DEF,
   parameter int TABLE_WAYS    = flt_pkg::TABLE_WAYS_DEF,
   parameter int BIN_COUNT     = flt_pkg::BIN_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  flt_pkg::req_type  req_payload,
   input  flt_pkg::cmd_type  cmd,
   output flt_pkg::sts_type  sts,
   output logic              rsp_valid,
   output flt_pkg::rsp_type  rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata
);

   localparam int SET_COUNT = TABLE_ENTRIES / TABLE_WAYS;
   localparam int SW        = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;
   localparam int WW        = TABLE_WAYS > 1 ? $clog2(TABLE_WAYS) : 1;
   localparam int BW        = BIN_COUNT > 1 ? $clog2(BIN_COUNT) : 1;
   localparam int ROW_W     = TABLE_WAYS * flt_pkg::ENTRY_W;
   localparam logic [SW-1:0] SET_LAST = SW'(SET_COUNT - 1);
   localparam logic [5:0]    BIN_LAST = 6'(BIN_COUNT - 1);

   logic [15:0]  watched_ff;
   flt_pkg::req_type req_ff;
   logic [15:0]  hash_ff, hash_in;
   logic [SW-1:0] clr_ff;
   logic [SW-1:0] set_idx;

   logic              vram_we, dram_we;
   logic [SW-1:0]     vram_waddr;
   logic [TABLE_WAYS-1:0] vram_wdata, vram_rdata;
   logic [ROW_W-1:0]  dram_wdata, dram_rdata;

   logic [TABLE_WAYS-1:0] hit_vec, free_vec;
   logic [WW-1:0]     hit_way, free_way, use_way;
   logic              any_hit, any_free;
   logic [63:0]       t0;
   logic [95:0]       key;

   logic [63:0]  dvd_ff, dvd_in;
   logic [63:0]  quo_ff, quo_in;
   logic [9:0]   rem_ff, rem_in;
   logic [15:0]  qc_ff, qc_in;
   logic         found_ff, found_in;
   logic [5:0]   lg_ff, lg_in;
   logic [BW-1:0] bkt;

   logic [63:0]  bins_ff [BIN_COUNT];
   logic [6:0]   sel_ext;
   logic [63:0]  bin_rd;

   logic         rsp_valid_ff;
   flt_pkg::rsp_type rsp_ff;

   assign key = {req_ff.local_addr, req_ff.remote_addr, req_ff.local_port,
                 req_ff.remote_port};
   assign set_idx = hash_ff[SW-1:0];

   // CSR
   always_ff @(posedge clock) begin
      if (reset) begin
         watched_ff <= flt_pkg::PORT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == flt_pkg::REG_WATCHED_PORT) begin
         watched_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == flt_pkg::REG_WATCHED_PORT) ?
                       {16'd0, watched_ff} : 32'd0;

   // request capture and set hash (modulo by set count, four bits a cycle)
   always_comb begin
      logic [31:0] m;
      logic [4:0]  k;
      hash_in = hash_ff;
      m = '0;
      k = '0;
      if (cmd.load) begin
         hash_in = req_payload.local_addr[15:0] ^ req_payload.local_addr[31:16] ^
                   req_payload.remote_addr[15:0] ^ req_payload.remote_addr[31:16] ^
                   req_payload.local_port ^ req_payload.remote_port;
      end else if (cmd.hash) begin
         for (int i = 0; i < 4; i++) begin
            k = 5'd15 - {1'b0, cmd.step[1:0], 2'(i)};
            m = 32'(SET_COUNT) << k;
            if ({16'd0, hash_in} >= m) begin
               hash_in = hash_in - m[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      hash_ff <= hash_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr) begin
         clr_ff <= clr_ff + SW'(1);
      end
   end

   // way selection
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      any_hit  = 1'b0;
      any_free = 1'b0;
      for (int j = 0; j < TABLE_WAYS; j++) begin
         hit_vec[j]  = vram_rdata[j] &&
                       dram_rdata[j*flt_pkg::ENTRY_W + flt_pkg::TIME_W +: flt_pkg::KEY_W]
                       == key;
         free_vec[j] = !vram_rdata[j];
      end
      for (int j = TABLE_WAYS - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            hit_way = WW'(j);
            any_hit = 1'b1;
         end
         if (free_vec[j]) begin
            free_way = WW'(j);
            any_free = 1'b1;
         end
      end
      use_way = any_hit ? hit_way : free_way;
      t0 = dram_rdata[32'(hit_way) * flt_pkg::ENTRY_W +: flt_pkg::TIME_W];
   end

   always_comb begin
      vram_we    = cmd.clr || cmd.wr_req || cmd.wr_rem;
      vram_waddr = cmd.clr ? clr_ff : set_idx;
      vram_wdata = vram_rdata;
      dram_wdata = dram_rdata;
      if (cmd.clr) begin
         vram_wdata = '0;
      end else if (cmd.wr_req) begin
         vram_wdata[use_way] = 1'b1;
         dram_wdata[32'(use_way) * flt_pkg::ENTRY_W +: flt_pkg::ENTRY_W] =
            {key, req_ff.time_ns};
      end else begin
         vram_wdata[hit_way] = 1'b0;
      end
      dram_we = cmd.wr_req;
   end

   flt_ram #(.WIDTH(TABLE_WAYS), .DEPTH(SET_COUNT)) u_valid_ram (
      .clock (clock),
      .we    (vram_we),
      .waddr (vram_waddr),
      .wdata (vram_wdata),
      .raddr (set_idx),
      .rdata (vram_rdata)
   );

   flt_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_entry_ram (
      .clock (clock),
      .we    (dram_we),
      .waddr (set_idx),
      .wdata (dram_wdata),
      .raddr (set_idx),
      .rdata (dram_rdata)
   );

   assign sts.watched   = req_payload.remote_port == watched_ff;
   assign sts.clr_last  = clr_ff == SET_LAST;
   assign sts.is_req    = req_ff.action == flt_pkg::ACT_REQUEST;
   assign sts.hit       = any_hit;
   assign sts.slot_ok   = any_hit || any_free;
   assign sts.backwards = req_ff.time_ns < t0;

   // divide by 1000 in 16-bit quotient chunks: even step forms the chunk by
   // reciprocal multiply, odd step the remainder and log2 track
   always_comb begin
      logic [25:0] v;
      logic [46:0] prod;
      logic [25:0] back;
      logic [3:0]  msb;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      qc_in    = qc_ff;
      found_in = found_ff;
      lg_in    = lg_ff;
      v    = {rem_ff, dvd_ff[63:48]};
      prod = '0;
      back = '0;
      msb  = '0;
      if (cmd.sub) begin
         dvd_in   = req_ff.time_ns - t0;
         quo_in   = '0;
         rem_in   = '0;
         qc_in    = '0;
         found_in = 1'b0;
         lg_in    = '0;
      end else if (cmd.div) begin
         if (!cmd.step[0]) begin
            prod  = 47'(v[25:3]) * 47'(flt_pkg::DIV_RECIP);
            qc_in = prod[45:30];
         end else begin
            back   = v - ({10'd0, qc_ff} * 26'(flt_pkg::NS_PER_US));
            rem_in = back[9:0];
            quo_in = {quo_ff[47:0], qc_ff};
            dvd_in = {dvd_ff[47:0], 16'd0};
            if (!found_ff && qc_ff != 16'd0) begin
               for (int i = 0; i < 16; i++) begin
                  if (qc_ff[i]) begin
                     msb = 4'(i);
                  end
               end
               found_in = 1'b1;
               lg_in    = {2'd3 - cmd.step[2:1], msb};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      qc_ff    <= qc_in;
      found_ff <= found_in;
      lg_ff    <= lg_in;
   end

   always_comb begin
      logic [5:0] b;
      b = !found_ff ? 6'd0 : (lg_ff > BIN_LAST ? BIN_LAST : lg_ff);
      bkt = b[BW-1:0];
   end

   // histogram
   assign sel_ext = {2'd0, req_ff.bin_select};
   assign bin_rd  = (sel_ext < 7'(BIN_COUNT)) ? bins_ff[sel_ext[BW-1:0]] : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BIN_COUNT; i++) begin
            bins_ff[i] <= '0;
         end
      end else if (cmd.bin_inc) begin
         bins_ff[bkt] <= bins_ff[bkt] + 64'd1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status     <= cmd.status;
         rsp_ff.bucket     <= '0;
         rsp_ff.latency_us <= '0;
         rsp_ff.bin_count  <= '0;
         if (cmd.status == flt_pkg::ST_COUNTED) begin
            rsp_ff.bucket     <= 5'(bkt);
            rsp_ff.latency_us <= quo_ff[54:0];
         end
         if (cmd.status == flt_pkg::ST_READ) begin
            rsp_ff.bin_count <= bin_rd;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/flow_request_latency_tracker.sv -----
// ---------------------------------------------------------------------------
// flow_request_latency_tracker
// Per-flow request to reply latency tracker with a log2 histogram.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Exactly one result
// follows, shown for one cycle with rsp_valid; the receiver cannot stall it.
// An ignored request (port not watched, bad reply, unknown action) is answered
// from the idle state and a bin read from the bin read state. A stored / table
// full / no match / time backwards result follows the four-step set hash
// reduction, the set read from the table RAM and the match; a counted reply
// then passes the divider by 1000 (reciprocal multiply, 16-bit quotient
// chunks) and the bin update. The result is registered before rsp_valid.
// One request is in flight at a time; busy is low again the cycle after the
// result is produced. After reset the valid RAM is swept, one set a cycle,
// over all TABLE_ENTRIES/TABLE_WAYS sets (2048 by default) with busy high;
// histogram bins clear at once. The user must write watched_port over the
// csr_ port only while no request is in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
module flow_request_latency_tracker #(
   parameter int TABLE_ENTRIES = flt_pkg::TABLE_ENTRIES_DEF,
   parameter int TABLE_WAYS    = flt_pkg::TABLE_WAYS_DEF,
   parameter int BIN_COUNT     = flt_pkg::BIN_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  flt_pkg::req_type  req_payload,
   output logic              rsp_valid,
   output flt_pkg::rsp_type  rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   flt_pkg::cmd_type cmd;
   flt_pkg::sts_type sts;

   assign csr_pready = 1'b1;

   flt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .sts         (sts),
      .busy        (busy),
      .cmd         (cmd)
   );

   flt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .TABLE_WAYS    (TABLE_WAYS),
      .BIN_COUNT     (BIN_COUNT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the flow request latency tracker.
// ---------------------------------------------------------------------------
// Requests go in on the start/busy port with random idle bursts; every result
// is checked field by field against a predictor that keeps its own flow table,
// histogram and watched port. Directed tests cover each action and corner
// case, then random request/reply traffic over a small pool of flows.
// ---------------------------------------------------------------------------
module testbench;

   localparam int WAYS     = flt_pkg::TABLE_WAYS_DEF;
   localparam int SETS     = flt_pkg::TABLE_ENTRIES_DEF / flt_pkg::TABLE_WAYS_DEF;
   localparam int BINS     = flt_pkg::BIN_COUNT_DEF;
   localparam int WDOG_MAX = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   flt_pkg::req_type req_payload = '0;
   logic        rsp_valid;
   flt_pkg::rsp_type rsp_payload;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   flow_request_latency_tracker u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [15:0] port_cfg;
   logic        tbl_valid [SETS*WAYS];
   logic [95:0] tbl_key [SETS*WAYS];
   logic [63:0] tbl_t0 [SETS*WAYS];
   logic [63:0] hist [BINS];
   flt_pkg::rsp_type pending_rsp [$];

   int  errors = 0;
   int  sent = 0;
   int  got = 0;
   int  wdog = 0;
   int  n_counted = 0;
   bit  idle_on = 1'b1;

   // flow pool for random traffic
   logic [95:0] pool_key [16];
   logic [63:0] now_ns;

   function automatic int flow_set(logic [95:0] k);
      logic [15:0] h;
      h = 16'h0;
      for (int i = 0; i < 6; i++) h ^= k[16*i +: 16];
      return h % SETS;
   endfunction

   function automatic flt_pkg::rsp_type predict_tracker(flt_pkg::req_type r);
      flt_pkg::rsp_type o;
      logic [95:0] k;
      logic [63:0] d;
      int          s, hit, slot, b;
      o = '0;
      k = {r.local_addr, r.remote_addr, r.local_port, r.remote_port};
      s = flow_set(k);
      hit = -1;
      slot = -1;
      if (r.action != flt_pkg::ACT_READ && r.action <= flt_pkg::ACT_REPLY) begin
         for (int w = WAYS-1; w >= 0; w--) begin
            if (tbl_valid[s*WAYS+w] && tbl_key[s*WAYS+w] == k) hit = s*WAYS+w;
            if (!tbl_valid[s*WAYS+w]) slot = s*WAYS+w;
         end
      end
      if (r.action == flt_pkg::ACT_REQUEST && r.remote_port == port_cfg) begin
         if (hit < 0) hit = slot;
         if (hit < 0) o.status = flt_pkg::ST_FULL;
         else begin
            tbl_valid[hit] = 1'b1;
            tbl_key[hit] = k;
            tbl_t0[hit] = r.time_ns;
            o.status = flt_pkg::ST_STORED;
         end
      end else if (r.action == flt_pkg::ACT_REPLY && r.reply_ok &&
                   r.remote_port == port_cfg) begin
         if (hit < 0) o.status = flt_pkg::ST_NOMATCH;
         else begin
            tbl_valid[hit] = 1'b0;
            if (r.time_ns < tbl_t0[hit]) o.status = flt_pkg::ST_BACKWARDS;
            else begin
               d = (r.time_ns - tbl_t0[hit]) / 64'd1000;
               b = 0;
               for (int i = 1; i < BINS; i++) if ((d >> i) != 0) b = i;
               hist[b] = hist[b] + 64'd1;
               o.status = flt_pkg::ST_COUNTED;
               o.bucket = b[4:0];
               o.latency_us = d[54:0];
               n_counted++;
            end
         end
      end else if (r.action == flt_pkg::ACT_READ) begin
         o.status = flt_pkg::ST_READ;
         if (r.bin_select < BINS) o.bin_count = hist[r.bin_select];
      end
      return o;
   endfunction

   task automatic idle_gap();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   task automatic send_request(flt_pkg::req_type r);
      idle_gap();
      req_payload <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(predict_tracker(r));
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_port(logic [15:0] p);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {flt_pkg::REG_WATCHED_PORT, 2'b00};
      csr_pwdata <= {16'($urandom_range(0, 65535)), p};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      port_cfg = p;
   endtask

   function automatic flt_pkg::req_type make_req(logic [1:0] act, logic [95:0] k,
                                                 logic [63:0] t);
      flt_pkg::req_type r;
      r = '0;
      r.action = act;
      {r.local_addr, r.remote_addr, r.local_port, r.remote_port} = k;
      r.time_ns = t;
      r.reply_ok = 1'b1;
      r.bin_select = 5'($urandom_range(0, 31));
      return r;
   endfunction

   task automatic read_bin(int b);
      flt_pkg::req_type r;
      r = make_req(flt_pkg::ACT_READ, {$urandom, $urandom, $urandom}, {$urandom, $urandom});
      r.bin_select = b[4:0];
      send_request(r);
   endtask

   // result checker
   always @(posedge clock) begin
      if (reset) wdog <= 0;
      else if (rsp_valid || (start && !busy)) wdog <= 0;
      else wdog <= wdog + 1;
      if (!reset && rsp_valid) begin
         flt_pkg::rsp_type e;
         got++;
         if (pending_rsp.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_payload.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_payload.status);
               errors++;
            end
            if (rsp_payload.bucket !== e.bucket) begin
               $error("bucket exp %0d got %0d", e.bucket, rsp_payload.bucket);
               errors++;
            end
            if (rsp_payload.latency_us !== e.latency_us) begin
               $error("latency_us exp %0d got %0d", e.latency_us, rsp_payload.latency_us);
               errors++;
            end
            if (rsp_payload.bin_count !== e.bin_count) begin
               $error("bin_count exp %0d got %0d", e.bin_count, rsp_payload.bin_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (wdog >= WDOG_MAX) begin
         $display("timeout: no progress");
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_basic_actions();
      logic [95:0] k;
      flt_pkg::req_type r;
      k = {32'h0a000001, 32'h0a000002, 16'd40000, 16'd53};
      send_request(make_req(flt_pkg::ACT_REQUEST, k, 64'd1000));
      send_request(make_req(flt_pkg::ACT_REQUEST, k, 64'd2000));          // overwrite
      send_request(make_req(flt_pkg::ACT_REPLY, k, 64'd2000 + 64'd5000000));
      send_request(make_req(flt_pkg::ACT_REPLY, k, 64'd9000000));         // no match now
      r = make_req(flt_pkg::ACT_REQUEST, k, 64'd10);
      r.remote_port = 16'd54;                                             // unwatched
      send_request(r);
      send_request(make_req(flt_pkg::ACT_REQUEST, k, 64'hffff_ffff_ffff_fff0));
      r = make_req(flt_pkg::ACT_REPLY, k, 64'd5);
      r.reply_ok = 1'b0;                                                  // bad reply
      send_request(r);
      send_request(make_req(flt_pkg::ACT_REPLY, k, 64'd5));               // backwards
      send_request(make_req(2'd3, k, 64'd5));                             // unknown action
      send_request(make_req(flt_pkg::ACT_REQUEST,
                            ~k & {80'h0, 16'h0} | {~k[95:16], 16'd53}, 64'd0));
      send_request(make_req(flt_pkg::ACT_REPLY, {~k[95:16], 16'd53},
                            64'hffff_ffff_ffff_ffff));
      send_request(make_req(flt_pkg::ACT_REQUEST, k, 64'd0));
      send_request(make_req(flt_pkg::ACT_REPLY, k, 64'd999));             // zero latency
      read_bin(0);
      read_bin(23);
      read_bin(24);
      read_bin(31);
      drain();
   endtask

   task automatic test_set_full();
      logic [95:0] k;
      // same set: vary local_addr low word and local_port together
      for (int i = 0; i < 5; i++) begin
         k = {16'h1234, 16'(i), 32'hc0a80001, 16'(i), port_cfg};
         send_request(make_req(flt_pkg::ACT_REQUEST, k, 64'd100));
      end
      for (int i = 0; i < 5; i++) begin
         k = {16'h1234, 16'(i), 32'hc0a80001, 16'(i), port_cfg};
         send_request(make_req(flt_pkg::ACT_REPLY, k, 64'd100 + (64'd1000 << (4*i))));
      end
      drain();
   endtask

   task automatic test_random_traffic(int n);
      int          f;
      flt_pkg::req_type r;
      logic [1:0]  a;
      for (int i = 0; i < 16; i++) begin
         pool_key[i] = {$urandom, $urandom, 16'($urandom), port_cfg};
         if (i >= 12) pool_key[i][15:0] = 16'($urandom); // mostly unwatched
      end
      for (int i = 0; i < n; i++) begin
         f = $urandom_range(0, 15);
         now_ns = {$urandom, $urandom};
         case ($urandom_range(0, 9))
            0, 1, 2, 3: a = flt_pkg::ACT_REQUEST;
            4, 5, 6, 7: a = flt_pkg::ACT_REPLY;
            8: a = flt_pkg::ACT_READ;
            default: a = 2'($urandom);
         endcase
         if ($urandom_range(0, 9) != 0) now_ns = 64'($urandom) << $urandom_range(0, 31);
         r = make_req(a, pool_key[f], now_ns);
         if ($urandom_range(0, 15) == 0) r.reply_ok = 1'b0;
         if (i > n - n/5) idle_on = 1'b0;
         send_request(r);
      end
      drain();
   endtask

   initial begin
      port_cfg = flt_pkg::PORT_RESET;
      for (int i = 0; i < SETS*WAYS; i++) tbl_valid[i] = 1'b0;
      for (int i = 0; i < BINS; i++) hist[i] = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_basic_actions();
      write_port(16'hffff);
      test_set_full();
      write_port(16'h0000);
      test_set_full();
      test_random_traffic(300);
      idle_on = 1'b1;
      write_port(16'd8080);
      test_random_traffic(350);
      idle_on = 1'b1;
      write_port(flt_pkg::PORT_RESET);
      test_random_traffic(330);
      for (int b = 0; b < BINS; b++) read_bin(b);
      drain();
      $display("covered %0d requests, %0d results, %0d latencies binned", sent, got,
               n_counted);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
